// ----- rtl/core/tdo_pkg.sv -----
// tdo_pkg: shared types, command codes and constants of the dominant
// orientation block. Used by tdo_ctrl, tdo_dp and tensor_dominant_orientation.
package tdo_pkg;

	localparam int MAX_STEPS = 32;

	localparam logic [16:0] ONE_Q15 = 17'd32768;
	localparam logic [16:0] START_Y = 17'd328;
	localparam logic [15:0] ERR_MAX = 16'hFFFF;
	localparam logic [24:0] EIG_MAX = 25'h1FFFFFF;
	localparam logic [15:0] TOL_RESET = 16'd655;
	localparam logic [5:0]  LIMIT_RESET = 6'd32;

	// config register indexes
	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;

	// datapath operations
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_LOAD      = 5'd1;
	localparam logic [4:0] OP_MUL       = 5'd2;
	localparam logic [4:0] OP_SHIFT     = 5'd3;
	localparam logic [4:0] OP_SQ        = 5'd4;
	localparam logic [4:0] OP_SQRT_INIT = 5'd5;
	localparam logic [4:0] OP_SQRT_STEP = 5'd6;
	localparam logic [4:0] OP_NORM      = 5'd7;
	localparam logic [4:0] OP_ERR_INIT  = 5'd8;
	localparam logic [4:0] OP_DIV_STEP  = 5'd9;
	localparam logic [4:0] OP_ERR_DONE  = 5'd10;
	localparam logic [4:0] OP_UX_INIT   = 5'd11;
	localparam logic [4:0] OP_UX_DONE   = 5'd12;
	localparam logic [4:0] OP_UY_INIT   = 5'd13;
	localparam logic [4:0] OP_UY_DONE   = 5'd14;
	localparam logic [4:0] OP_COR_INIT  = 5'd15;
	localparam logic [4:0] OP_COR_STEP  = 5'd16;
	localparam logic [4:0] OP_OUT       = 5'd17;
	localparam logic [4:0] OP_OUT_ZERO  = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic [4:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic zero_tensor;
		logic norm_zero;
		logic converged;
	} dp_stat_t;

	// CORDIC angle table, units of pi / 2^20
	function automatic logic [19:0] atan_units(input logic [3:0] i);
		logic [19:0] r;
		unique case (i)
			4'd0:  r = 20'd262144;
			4'd1:  r = 20'd154753;
			4'd2:  r = 20'd81767;
			4'd3:  r = 20'd41506;
			4'd4:  r = 20'd20834;
			4'd5:  r = 20'd10427;
			4'd6:  r = 20'd5215;
			4'd7:  r = 20'd2608;
			4'd8:  r = 20'd1304;
			4'd9:  r = 20'd652;
			4'd10: r = 20'd326;
			4'd11: r = 20'd163;
			4'd12: r = 20'd81;
			4'd13: r = 20'd41;
			4'd14: r = 20'd20;
			4'd15: r = 20'd10;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/tensor_dominant_orientation.sv -----
// One item runs from the start beat to the done strobe through n refinement steps
// (0..32). The block takes one item at a time; each refinement step is set by the
// square root and three divisions on one shared divider. The CORDIC runs at the end.
// Reset (arst_n low): controller idle, tolerance 655, iteration limit 32, done low.
// The result is shown for one cycle with done high; the receiver cannot stall it.
module tensor_dominant_orientation (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] txx,
	input  logic signed [23:0] txy,
	input  logic signed [23:0] tyx,
	input  logic signed [23:0] tyy,
	// config write port
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [15:0]        wr_data,
	// result beat
	output logic               done,
	output logic               valid_res,
	output logic [15:0]        orientation,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic [24:0]        eigenvalue,
	output logic [15:0]        rel_error
);
	import tdo_pkg::*;

	logic [15:0] tol_q;
	logic [5:0]  limit_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;

	// config registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_RESET;
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_TOL)   tol_q   <= wr_data;
			if (wr_index == REG_LIMIT) limit_q <= wr_data[5:0];
		end
	end

	// sequencer: one command per cycle to the datapath
	tdo_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.limit  (limit_q),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// arithmetic, status flags and the registered result beat
	tdo_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.tol         (tol_q),
		.txx         (txx),
		.txy         (txy),
		.tyx         (tyx),
		.tyy         (tyy),
		.stat        (stat),
		.done        (done),
		.valid_res   (valid_res),
		.orientation (orientation),
		.dir_x       (dir_x),
		.dir_y       (dir_y),
		.eigenvalue  (eigenvalue),
		.rel_error   (rel_error)
	);

endmodule

// ----- rtl/core/tdo_ctrl.sv -----
// tdo_ctrl: sequencer of the power iteration; issues one datapath command per cycle.
// Depends on tdo_pkg.
module tdo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [5:0]         limit,
	input  tdo_pkg::dp_stat_t  stat,
	output tdo_pkg::dp_cmd_t   cmd,
	output logic               busy
);
	import tdo_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_CHECK = 5'd1;
	localparam logic [4:0] ST_ZERO  = 5'd2;
	localparam logic [4:0] ST_MUL   = 5'd3;
	localparam logic [4:0] ST_SHIFT = 5'd4;
	localparam logic [4:0] ST_SQ    = 5'd5;
	localparam logic [4:0] ST_SQRTI = 5'd6;
	localparam logic [4:0] ST_SQRT  = 5'd7;
	localparam logic [4:0] ST_NORM  = 5'd8;
	localparam logic [4:0] ST_NCHK  = 5'd9;
	localparam logic [4:0] ST_ERRI  = 5'd10;
	localparam logic [4:0] ST_EDIV  = 5'd11;
	localparam logic [4:0] ST_ERRD  = 5'd12;
	localparam logic [4:0] ST_UXI   = 5'd13;
	localparam logic [4:0] ST_XDIV  = 5'd14;
	localparam logic [4:0] ST_UXD   = 5'd15;
	localparam logic [4:0] ST_UYI   = 5'd16;
	localparam logic [4:0] ST_YDIV  = 5'd17;
	localparam logic [4:0] ST_UYD   = 5'd18;
	localparam logic [4:0] ST_LOOP  = 5'd19;
	localparam logic [4:0] ST_CORI  = 5'd20;
	localparam logic [4:0] ST_COR   = 5'd21;
	localparam logic [4:0] ST_OUT   = 5'd22;

	localparam logic [4:0] MUL_LAST  = 5'd3;
	localparam logic [4:0] SQ_LAST   = 5'd1;
	localparam logic [4:0] SQRT_LAST = 5'd31;
	localparam logic [4:0] DIV_LAST  = 5'd16;
	localparam logic [4:0] COR_LAST  = 5'd15;

	logic [4:0] state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [5:0] it_q, it_d;
	logic       first_q, first_d;
	logic [5:0] cap;

	assign cap  = (limit > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : limit;
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		it_d    = it_q;
		first_d = first_q;
		cmd.op  = OP_NONE;
		cmd.idx = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					cnt_d   = '0;
					it_d    = '0;
					first_d = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: state_d = stat.zero_tensor ? ST_ZERO : ST_MUL;
			ST_ZERO: begin
				cmd.op  = OP_OUT_ZERO;
				state_d = ST_IDLE;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.op  = OP_SHIFT;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == SQ_LAST) begin
					cnt_d   = '0;
					state_d = ST_SQRTI;
				end
			end
			ST_SQRTI: begin
				cmd.op  = OP_SQRT_INIT;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				cmd.op  = OP_NORM;
				state_d = ST_NCHK;
			end
			ST_NCHK: begin
				priority if (stat.norm_zero) state_d = ST_ZERO;
				else if (first_q)            state_d = ST_UXI;
				else                         state_d = ST_ERRI;
			end
			ST_ERRI: begin
				cmd.op  = OP_ERR_INIT;
				state_d = ST_EDIV;
			end
			ST_EDIV, ST_XDIV, ST_YDIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					unique case (state_q)
						ST_EDIV: state_d = ST_ERRD;
						ST_XDIV: state_d = ST_UXD;
						default: state_d = ST_UYD;
					endcase
				end
			end
			ST_ERRD: begin
				cmd.op  = OP_ERR_DONE;
				state_d = ST_UXI;
			end
			ST_UXI: begin
				cmd.op  = OP_UX_INIT;
				state_d = ST_XDIV;
			end
			ST_UXD: begin
				cmd.op  = OP_UX_DONE;
				state_d = ST_UYI;
			end
			ST_UYI: begin
				cmd.op  = OP_UY_INIT;
				state_d = ST_YDIV;
			end
			ST_UYD: begin
				cmd.op  = OP_UY_DONE;
				state_d = ST_LOOP;
			end
			ST_LOOP: begin
				if (first_q) begin
					first_d = 1'b0;
					state_d = (cap == '0) ? ST_CORI : ST_MUL;
				end else begin
					it_d    = it_q + 6'd1;
					state_d = (stat.converged || (it_q + 6'd1 == cap)) ? ST_CORI : ST_MUL;
				end
			end
			ST_CORI: begin
				cmd.op  = OP_COR_INIT;
				state_d = ST_COR;
			end
			ST_COR: begin
				cmd.op = OP_COR_STEP;
				cnt_d  = cnt_q + 5'd1;
				if (cnt_q == COR_LAST) begin
					cnt_d   = '0;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.op  = OP_OUT;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			it_q    <= '0;
			first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			it_q    <= it_d;
			first_q <= first_d;
		end
	end

endmodule

// ----- rtl/core/tdo_dp.sv -----
// tdo_dp: datapath - shared multipliers, bit-serial square root and divider, CORDIC.
// Depends on tdo_pkg; driven by tdo_ctrl commands.
module tdo_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  tdo_pkg::dp_cmd_t    cmd,
	input  logic [15:0]         tol,
	input  logic signed [23:0]  txx,
	input  logic signed [23:0]  txy,
	input  logic signed [23:0]  tyx,
	input  logic signed [23:0]  tyy,
	output tdo_pkg::dp_stat_t   stat,
	output logic                done,
	output logic                valid_res,
	output logic [15:0]         orientation,
	output logic signed [15:0]  dir_x,
	output logic signed [15:0]  dir_y,
	output logic [24:0]         eigenvalue,
	output logic [15:0]         rel_error
);
	import tdo_pkg::*;

	logic signed [23:0] a0_q, a1_q, a2_q, a3_q;
	logic signed [16:0] x0_q, x1_q;
	logic signed [41:0] p0_q, p1_q;
	logic [3:0]  sh_q;
	logic [30:0] ma_q, mb_q;
	logic [62:0] sum_q;
	logic [62:0] sn_q, sr_q, sb_q;
	logic [41:0] c_q, cn_q;
	logic [59:0] rem_q, dsh_q;
	logic [16:0] quo_q;
	logic        sat_q;
	logic [15:0] err_q;
	logic signed [33:0] u_q, v_q;
	logic signed [21:0] z_q;
	logic        done_q;

	// tensor multiplier operands
	logic signed [23:0] mul_a;
	logic signed [16:0] mul_x;
	logic signed [40:0] prod;
	logic signed [41:0] prod_x;
	// magnitudes and shift
	logic signed [41:0] neg0, neg1;
	logic [40:0] mag0, mag1, mmax;
	logic [3:0]  sh;
	logic [40:0] sa, sb;
	// squares
	logic [30:0] sq_op;
	logic [61:0] sq;
	// sqrt step
	logic [62:0] trial;
	// divider setup
	logic [41:0] dnorm;
	logic [59:0] err_num, ux_num, uy_num, half_cn;
	// unit component
	logic [16:0] qc;
	// cordic
	logic signed [33:0] cu, cv, du, dv;
	logic [3:0]  ci;
	logic signed [21:0] zstep, zr;
	logic [42:0] eig_sum;
	logic [27:0] eig_raw;

	assign mul_a = cmd.idx[1] ? (cmd.idx[0] ? a3_q : a2_q) : (cmd.idx[0] ? a1_q : a0_q);
	assign mul_x = cmd.idx[0] ? x1_q : x0_q;
	assign prod  = mul_a * mul_x;
	assign prod_x = 42'(prod);

	assign neg0 = -p0_q;
	assign neg1 = -p1_q;
	assign mag0 = p0_q[41] ? neg0[40:0] : p0_q[40:0];
	assign mag1 = p1_q[41] ? neg1[40:0] : p1_q[40:0];
	assign mmax = (mag0 > mag1) ? mag0 : mag1;

	// least shift that brings both magnitudes below 2^31
	always_comb begin
		sh = '0;
		for (int j = 0; j < 10; j++) begin
			if (mmax[31 + j]) sh = 4'(j + 1);
		end
	end
	assign sa = mag0 >> sh;
	assign sb = mag1 >> sh;

	assign sq_op = cmd.idx[0] ? mb_q : ma_q;
	assign sq    = sq_op * sq_op;

	assign trial = sr_q + sb_q;

	assign half_cn = 60'(cn_q >> 1);
	assign dnorm   = (c_q > cn_q) ? (c_q - cn_q) : (cn_q - c_q);
	assign err_num = {2'b00, dnorm, 16'h0000} + half_cn;
	assign ux_num  = {4'h0, mag0, 15'h0000} + half_cn;
	assign uy_num  = {4'h0, mag1, 15'h0000} + half_cn;

	assign qc = (sat_q || quo_q > ONE_Q15) ? ONE_Q15 : quo_q;

	assign cu = x1_q[16] ? -34'(x1_q) : 34'(x1_q);
	assign cv = x1_q[16] ? -34'(x0_q) : 34'(x0_q);
	assign ci = cmd.idx[3:0];
	assign du = v_q >>> ci;
	assign dv = u_q >>> ci;
	assign zstep = 22'(atan_units(ci));
	assign zr = z_q + 22'sd8;

	assign eig_sum = 43'(cn_q) + 43'd16384;
	assign eig_raw = eig_sum[42:15];

	assign stat.zero_tensor = (a0_q == '0) && (a1_q == '0) && (a3_q == '0);
	assign stat.norm_zero   = (cn_q == '0);
	assign stat.converged   = (err_q < tol);
	assign done = done_q;

	task automatic div_load(input logic [59:0] num);
		rem_q <= num;
		dsh_q <= 60'(cn_q) << 16;
		sat_q <= num >= (60'(cn_q) << 17);
		quo_q <= '0;
	endtask

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				a0_q  <= txx;
				a1_q  <= txy;
				a2_q  <= tyx;
				a3_q  <= tyy;
				x0_q  <= ONE_Q15;
				x1_q  <= START_Y;
				err_q <= ERR_MAX;
			end
			OP_MUL: begin
				unique case (cmd.idx[1:0])
					2'd0: p0_q <= prod_x;
					2'd1: p0_q <= p0_q + prod_x;
					2'd2: p1_q <= prod_x;
					default: p1_q <= p1_q + prod_x;
				endcase
			end
			OP_SHIFT: begin
				sh_q <= sh;
				ma_q <= sa[30:0];
				mb_q <= sb[30:0];
			end
			OP_SQ: sum_q <= cmd.idx[0] ? (sum_q + 63'(sq)) : 63'(sq);
			OP_SQRT_INIT: begin
				sn_q <= sum_q;
				sr_q <= '0;
				sb_q <= 63'h1 << 62;
			end
			OP_SQRT_STEP: begin
				if (sn_q >= trial) begin
					sn_q <= sn_q - trial;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			OP_NORM: begin
				c_q  <= cn_q;
				cn_q <= 42'(sr_q[31:0]) << sh_q;
			end
			OP_ERR_INIT: div_load(err_num);
			OP_UX_INIT:  div_load(ux_num);
			OP_UY_INIT:  div_load(uy_num);
			OP_DIV_STEP: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					quo_q <= {quo_q[15:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			OP_ERR_DONE: err_q <= (sat_q || quo_q > 17'(ERR_MAX)) ? ERR_MAX : quo_q[15:0];
			OP_UX_DONE:  x0_q <= p0_q[41] ? -qc : qc;
			OP_UY_DONE:  x1_q <= p1_q[41] ? -qc : qc;
			OP_COR_INIT: begin
				u_q <= cu <<< 14;
				v_q <= cv <<< 14;
				z_q <= '0;
			end
			OP_COR_STEP: begin
				if (v_q > 0) begin
					u_q <= u_q + du;
					v_q <= v_q - dv;
					z_q <= z_q + zstep;
				end else begin
					u_q <= u_q - du;
					v_q <= v_q + dv;
					z_q <= z_q - zstep;
				end
			end
			OP_OUT: begin
				orientation <= zr[19:4];
				dir_x       <= (x0_q == ONE_Q15) ? 16'sd32767 : x0_q[15:0];
				dir_y       <= (x1_q == ONE_Q15) ? 16'sd32767 : x1_q[15:0];
				eigenvalue  <= (eig_raw > 28'(EIG_MAX)) ? EIG_MAX : eig_raw[24:0];
				rel_error   <= err_q;
			end
			OP_OUT_ZERO: begin
				orientation <= '0;
				dir_x       <= '0;
				dir_y       <= '0;
				eigenvalue  <= '0;
				rel_error   <= '0;
			end
			default: ;
		endcase
	end

	// result strobe and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			valid_res <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT) || (cmd.op == OP_OUT_ZERO);
			if (cmd.op == OP_OUT)      valid_res <= 1'b1;
			if (cmd.op == OP_OUT_ZERO) valid_res <= 1'b0;
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for tensor_dominant_orientation (power-iteration
// eigenvector of a 2x2 tensor). Depends on tdo_pkg and the DUT source only.
`timescale 1ns / 100ps

module tb_top;
	import tdo_pkg::*;

	typedef struct packed {
		logic signed [23:0] axx;
		logic signed [23:0] axy;
		logic signed [23:0] ayx;
		logic signed [23:0] ayy;
	} tensor_t;

	typedef struct packed {
		logic               ok;
		logic [15:0]        ang;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic [24:0]        lam;
		logic [15:0]        err;
	} eigen_t;

	// timeout budget for the ~1770 items at their worst length
	localparam int CYCLE_LIMIT = 25_000_000;
	localparam int DRAIN_CYCLES = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [23:0] txx = '0, txy = '0, tyx = '0, tyy = '0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	logic done, valid_res;
	logic [15:0] orientation, rel_error;
	logic signed [15:0] dir_x, dir_y;
	logic [24:0] eigenvalue;

	tensor_dominant_orientation DUT (.*);

	always #10 clk = ~clk;

	// predictor copy of the registers
	logic [15:0] tol_q = TOL_RESET;
	logic [5:0]  limit_q = LIMIT_RESET;

	tensor_t tensor_q[$];     // tensors waiting for the driver
	eigen_t  eigen_q[$];      // expected results in issue order
	int      idle_pct = 8;    // sender idle chance, percent
	bit      hold_sender = 1'b0;
	int      n_err = 0, n_beats = 0, n_invalid = 0;
	longint  cycles = 0;

	// ---------------- predictor ----------------
	function automatic longint unsigned umag(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// norm with pre-shift so the squares stay in 64 bits
	function automatic longint unsigned norm2(longint p, longint q);
		longint unsigned a, b, m;
		int s;
		a = umag(p);
		b = umag(q);
		m = a > b ? a : b;
		s = 0;
		while ((m >> s) >= (64'd1 << 31)) s++;
		a >>= s;
		b >>= s;
		return int_sqrt(a * a + b * b) << s;
	endfunction

	function automatic longint to_unit(longint p, longint unsigned c);
		longint unsigned q;
		q = (umag(p) * 32768 + c / 2) / c;
		if (q > 32768) q = 32768;
		return p < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [15:0] cordic_angle(longint x, longint y);
		longint u, v, z, du, dv;
		u = y;
		v = x;
		z = 0;
		if (u < 0) begin
			u = -u;
			v = -v;
		end
		u *= 16384;
		v *= 16384;
		for (int i = 0; i < 16; i++) begin
			du = v >>> i;
			dv = u >>> i;
			if (v > 0) begin
				u += du; v -= dv; z += longint'(atan_units(i[3:0]));
			end else begin
				u -= du; v += dv; z -= longint'(atan_units(i[3:0]));
			end
		end
		return 16'((z + 8) >>> 4);
	endfunction

	function automatic eigen_t dominant_eigen(tensor_t t);
		eigen_t r;
		longint a0, a1, a2, a3, x0, x1, p0, p1;
		longint unsigned c, cn, d, err, lam;
		int cap;
		r = '0;
		a0 = t.axx; a1 = t.axy; a2 = t.ayx; a3 = t.ayy;
		if (a0 == 0 && a1 == 0 && a3 == 0) return r;
		x0 = 32768;
		x1 = 328;
		err = 65535;
		p0 = a0 * x0 + a1 * x1;
		p1 = a2 * x0 + a3 * x1;
		c = norm2(p0, p1);
		if (c == 0) return r;
		x0 = to_unit(p0, c);
		x1 = to_unit(p1, c);
		cap = limit_q < MAX_STEPS ? limit_q : MAX_STEPS;
		for (int i = 0; i < cap; i++) begin
			p0 = a0 * x0 + a1 * x1;
			p1 = a2 * x0 + a3 * x1;
			cn = norm2(p0, p1);
			if (cn == 0) return r;
			d = c > cn ? c - cn : cn - c;
			err = (d * 65536 + cn / 2) / cn;
			if (err > 65535) err = 65535;
			c = cn;
			x0 = to_unit(p0, c);
			x1 = to_unit(p1, c);
			if (err < tol_q) break;
		end
		lam = (c + 16384) >> 15;
		if (lam > EIG_MAX) lam = EIG_MAX;
		r.ok = 1'b1;
		r.ang = cordic_angle(x0, x1);
		r.ux = 16'(x0 > 32767 ? 32767 : x0);   // +1.0 saturates
		r.uy = 16'(x1 > 32767 ? 32767 : x1);
		r.lam = 25'(lam);
		r.err = 16'(err);
		return r;
	endfunction

	// ---------------- driver ----------------
	// start rises on the falling edge; expectation is logged on the accepting edge
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			eigen_q.push_back(dominant_eigen('{txx, txy, tyx, tyy}));
		end
	end

	// prepare the next beat at the falling edge after acceptance
	bit taken = 1'b0;
	always @(posedge clk) taken <= arst_n && start && !busy;

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !taken) begin
				// beat still pending
			end else if (tensor_q.size() > 0 && !hold_sender &&
					$urandom_range(99) >= idle_pct) begin
				tensor_t t;
				t = tensor_q.pop_front();
				txx <= t.axx; txy <= t.axy; tyx <= t.ayx; tyy <= t.ayy;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			eigen_t exp_r, got;
			got = '{valid_res, orientation, dir_x, dir_y, eigenvalue, rel_error};
			n_beats++;
			if (!valid_res) n_invalid++;
			if (eigen_q.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("unexpected result beat: %p", got);
			end else begin
				exp_r = eigen_q.pop_front();
				if (got !== exp_r) begin
					n_err++;
					if (n_err <= 10)
						$display({"mismatch: exp ok=%0d ang=%0d x=%0d y=%0d lam=%0d err=%0d",
							" / got ok=%0d ang=%0d x=%0d y=%0d lam=%0d err=%0d"},
							exp_r.ok, exp_r.ang, exp_r.ux, exp_r.uy, exp_r.lam, exp_r.err,
							got.ok, got.ang, got.ux, got.uy, got.lam, got.err);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", eigen_q.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic logic signed [23:0] rnd_entry();
		unique case ($urandom_range(5))
			0: return 24'sd0;
			1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
			2: return 24'($signed(7'($urandom)));      // tiny
			3: return 24'($signed(14'($urandom)));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic tensor_t rnd_tensor();
		tensor_t t;
		logic signed [23:0] s;
		t = '{rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry()};
		// half are symmetric tensors, the common case for orientation fields
		if ($urandom_range(1)) begin
			t.ayx = t.axy;
			if ($urandom_range(3) == 0) begin
				s = 24'($urandom_range(1000000));
				t.axx = s; t.ayy = s; t.axy = '0; t.ayx = '0;
			end
		end
		return t;
	endfunction

	task automatic wait_drained();
		while (tensor_q.size() > 0 || start || eigen_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		if (idx == REG_TOL) tol_q = val;
		else if (idx == REG_LIMIT) limit_q = val[5:0];
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: extremes, zero tensor (tyx ignored), pure rotations
		tensor_q.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sd0});
		tensor_q.push_back('{24'sd0, 24'sd0, 24'sh7FFFFF, 24'sd0});
		tensor_q.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
		tensor_q.push_back('{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000});
		tensor_q.push_back('{24'sh7FFFFF, 24'sd0, 24'sd0, 24'sd0});
		tensor_q.push_back('{24'sd0, 24'sd0, 24'sd0, 24'sh7FFFFF});
		tensor_q.push_back('{24'sd0, 24'sd0, 24'sd0, -24'sd1});
		tensor_q.push_back('{24'sd1, 24'sd0, 24'sd0, 24'sd1});
		tensor_q.push_back('{24'sd1, 24'sd0, 24'sd0, 24'sd0});
		tensor_q.push_back('{-24'sd1, 24'sd0, 24'sd0, 24'sd0});
		tensor_q.push_back('{24'sd0, 24'sd1, 24'sd1, 24'sd0});
		tensor_q.push_back('{24'sd0, 24'sd1, -24'sd1, 24'sd0});
		tensor_q.push_back('{24'sd0, -24'sd1, 24'sd1, 24'sd0});
		tensor_q.push_back('{24'sd100, 24'sd50, 24'sd50, 24'sd100});
		tensor_q.push_back('{24'sd100, -24'sd50, -24'sd50, 24'sd100});
		tensor_q.push_back('{24'sd1, 24'sd0, 24'sd0, 24'sd1000});
		tensor_q.push_back('{24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA});
		wait_drained();

		// random phases over register settings, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin write_reg(REG_TOL, 16'd0); write_reg(REG_LIMIT, 16'd1); end
				1: begin write_reg(REG_TOL, 16'hFFFF); write_reg(REG_LIMIT, 16'd63); end
				2: begin write_reg(REG_TOL, 16'd0); write_reg(REG_LIMIT, 16'd0); end
				3: begin write_reg(REG_TOL, 16'd0); write_reg(REG_LIMIT, 16'd32); end
				4: begin write_reg(REG_TOL, TOL_RESET); write_reg(REG_LIMIT, 16'd5); end
				5: begin write_reg(REG_TOL, 16'($urandom)); write_reg(REG_LIMIT, 16'($urandom)); end
				default: begin write_reg(REG_TOL, TOL_RESET); write_reg(REG_LIMIT, 16'd33); end
			endcase
			idle_pct = ph < 2 ? 8 : (ph < 4 ? 78 : 0);
			for (int n = 0; n < 250; n++) begin
				tensor_q.push_back(rnd_tensor());
				// mid-phase: let the first half go out, then hold the sender
				// until the block has fully drained
				if (n == 125) begin
					while (tensor_q.size() > 0) @(posedge clk);
					hold_sender = 1'b1;
					while (start || eigen_q.size() > 0) @(posedge clk);
					hold_sender = 1'b0;
				end
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d result beats checked, %0d of them flagged invalid, over 8 register settings",
			n_beats, n_invalid);
		if (n_err == 0 && eigen_q.size() == 0)
			$display("All tests passed");
		else begin
			$display("%0d mismatches", n_err);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
